@@ hw/rtl/salt_pkg.sv @@
// ----------------------------------------------------------------------------
// salt_pkg
// Shared types and constants for the set-associative LRU translation buffer.
// ----------------------------------------------------------------------------
package salt_pkg;

  localparam int LOG_SETS = 10;
  localparam int WAYS     = 2;
  localparam int SETS     = 1 << LOG_SETS;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam int VA_W    = 32;
  localparam int FRAME_W = 32;
  localparam int TAG_W   = VA_W - LOG_SETS;
  localparam int STAMP_W = 64;
  localparam int CNT_W   = 32;
  localparam int LPS_W   = 5;

  localparam logic [LPS_W-1:0] LPS_RESET = LPS_W'(12);

  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_FILL   = 2'd1;
  localparam logic [1:0] KIND_FLUSH  = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [VA_W-1:0]    virtual_address;
    logic [FRAME_W-1:0] translation;
  } in_word_t;

  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] physical_frame;
    logic [CNT_W-1:0]   hit_total;
    logic [CNT_W-1:0]   miss_total;
    logic [CNT_W-1:0]   flush_total;
  } out_word_t;

  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [FRAME_W-1:0] frame;
    logic [STAMP_W-1:0] stamp;
  } way_t;

  typedef way_t [WAYS-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_FLUSH,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic accept;
    logic rd_en;
    logic update;
    logic sweep_wr;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic sweep_last;
  } dp_status_t;

endpackage

@@ hw/rtl/set_associative_lru_tlb.sv @@
// ----------------------------------------------------------------------------
// set_associative_lru_tlb
// Set-associative translation buffer with LRU replacement and usage counters.
// ----------------------------------------------------------------------------
// Usage:
//   in_word (kind, virtual_address, translation) enters on in_valid/in_ready;
//   one result word (hit, physical_frame, hit/miss/flush totals) leaves on
//   out_valid/out_ready for every input word. cfg_data sets log2 of the page
//   size on cfg_valid; cfg_ready is always high. Write it only while idle.
//   Lookups and fills pass from accept through the registered set read, the
//   way compare and write back, and the load of the output register. The
//   next word is accepted only once the output register is loaded, so the
//   block takes no new word before it is through with the last one, set by
//   the sequential read-modify-write of the entry RAM.
//   A flush clears the entry RAM one set per cycle, then loads its result.
//   After reset the same clearing pass runs with in_ready low. A result
//   waiting on out_ready does not block the next accept; the following
//   result waits until the output register is taken.
// ----------------------------------------------------------------------------
module set_associative_lru_tlb
  import salt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_word,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_word,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LPS_W-1:0] cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  salt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_word.kind),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  salt_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_word   (in_word),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_word  (out_word),
    .status    (status)
  );

endmodule

@@ hw/rtl/salt_ram.sv @@
// ----------------------------------------------------------------------------
// salt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module salt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/salt_ctrl.sv @@
// ----------------------------------------------------------------------------
// salt_ctrl
// Sequencer: clearing sweep, read, update, flush sweep and result handoff.
// ----------------------------------------------------------------------------
module salt_ctrl
  import salt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_kind,
  input  dp_status_t status,
  output logic       in_ready,
  output ctrl_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_INIT: begin
        cmd.sweep_wr = 1'b1;
        if (status.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = (in_kind == KIND_FLUSH) ? ST_FLUSH : ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_RESP;
      end
      ST_FLUSH: begin
        cmd.sweep_wr = 1'b1;
        if (status.sweep_last) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

endmodule

@@ hw/rtl/salt_dpath.sv @@
// ----------------------------------------------------------------------------
// salt_dpath
// Entry RAM, address split, way match and victim choice, counters, output.
// ----------------------------------------------------------------------------
module salt_dpath
  import salt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  ctrl_cmd_t        cmd,
  input  in_word_t         in_word,
  input  logic             cfg_valid,
  input  logic [LPS_W-1:0] cfg_data,
  input  logic             out_ready,
  output logic             out_valid,
  output out_word_t        out_word,
  output dp_status_t       status
);

  logic [LPS_W-1:0]    lps_r;
  logic [1:0]          kind_r;
  logic [LOG_SETS-1:0] set_r;
  logic [TAG_W-1:0]    tag_r;
  logic [FRAME_W-1:0]  fill_r;
  logic [STAMP_W-1:0]  stamp_r;
  logic [CNT_W-1:0]    hits_r;
  logic [CNT_W-1:0]    misses_r;
  logic [CNT_W-1:0]    flushes_r;
  logic [LOG_SETS-1:0] sweep_idx_r;
  logic                res_hit_r;
  logic [FRAME_W-1:0]  res_frame_r;
  logic                out_valid_r;
  out_word_t           out_word_r;

  logic [VA_W-1:0]     vpn;
  logic [STAMP_W-1:0]  stamp_inc;
  logic [ROW_W-1:0]    rd_data;
  row_t                row_rd;
  row_t                row_wr;
  logic                upd_wr;
  logic                lookup_hit;
  logic [FRAME_W-1:0]  hit_frame;
  logic                ram_wr_en;
  logic [LOG_SETS-1:0] ram_wr_addr;
  logic [ROW_W-1:0]    ram_wr_data;

  assign vpn       = in_word.virtual_address >> lps_r;
  assign stamp_inc = stamp_r + STAMP_W'(1);
  assign row_rd    = row_t'(rd_data);

  always_comb begin
    logic               match_found;
    logic               free_found;
    logic [WAY_W-1:0]   match_way;
    logic [WAY_W-1:0]   free_way;
    logic [WAY_W-1:0]   lru_way;
    logic [WAY_W-1:0]   victim;
    logic [STAMP_W-1:0] oldest;
    match_found = 1'b0;
    free_found  = 1'b0;
    match_way   = '0;
    free_way    = '0;
    lru_way     = '0;
    oldest      = row_rd[0].stamp;
    for (int w = 0; w < WAYS; w++) begin
      if (!match_found && row_rd[w].valid && row_rd[w].tag == tag_r) begin
        match_found = 1'b1;
        match_way   = WAY_W'(w);
      end
      if (!free_found && !row_rd[w].valid) begin
        free_found = 1'b1;
        free_way   = WAY_W'(w);
      end
      if (row_rd[w].stamp < oldest) begin
        oldest  = row_rd[w].stamp;
        lru_way = WAY_W'(w);
      end
    end
    priority if (match_found) begin
      victim = match_way;
    end else if (free_found) begin
      victim = free_way;
    end else begin
      victim = lru_way;
    end

    row_wr     = row_rd;
    upd_wr     = 1'b0;
    lookup_hit = 1'b0;
    hit_frame  = row_rd[match_way].frame;
    if (kind_r == KIND_LOOKUP && match_found) begin
      lookup_hit                = 1'b1;
      upd_wr                    = 1'b1;
      row_wr[match_way].stamp   = stamp_inc;
    end else if (kind_r == KIND_FILL && fill_r != '0) begin
      upd_wr         = 1'b1;
      row_wr[victim] = {1'b1, tag_r, fill_r, stamp_inc};
    end
  end

  assign ram_wr_en   = cmd.sweep_wr | (cmd.update & upd_wr);
  assign ram_wr_addr = cmd.sweep_wr ? sweep_idx_r : set_r;
  assign ram_wr_data = cmd.sweep_wr ? '0 : ROW_W'(row_wr);

  salt_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (set_r),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lps_r       <= LPS_RESET;
      stamp_r     <= '0;
      hits_r      <= '0;
      misses_r    <= '0;
      flushes_r   <= '0;
      sweep_idx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        lps_r <= cfg_data;
      end
      if (cmd.sweep_wr) begin
        sweep_idx_r <= sweep_idx_r + LOG_SETS'(1);
      end
      if (cmd.accept && in_word.kind == KIND_FLUSH) begin
        flushes_r <= flushes_r + CNT_W'(1);
      end
      if (cmd.update) begin
        if (upd_wr) begin
          stamp_r <= stamp_inc;
        end
        if (kind_r == KIND_LOOKUP) begin
          if (lookup_hit) begin
            hits_r <= hits_r + CNT_W'(1);
          end else begin
            misses_r <= misses_r + CNT_W'(1);
          end
        end
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r      <= in_word.kind;
      set_r       <= vpn[LOG_SETS-1:0];
      tag_r       <= vpn[VA_W-1:LOG_SETS];
      fill_r      <= in_word.translation;
      res_hit_r   <= 1'b0;
      res_frame_r <= '0;
    end else if (cmd.update && lookup_hit) begin
      res_hit_r   <= 1'b1;
      res_frame_r <= hit_frame;
    end
    if (cmd.load_out) begin
      out_word_r <= '{hit:            res_hit_r,
                      physical_frame: res_frame_r,
                      hit_total:      hits_r,
                      miss_total:     misses_r,
                      flush_total:    flushes_r};
    end
  end

  assign out_valid         = out_valid_r;
  assign out_word          = out_word_r;
  assign status.out_free   = !out_valid_r || out_ready;
  assign status.sweep_last = (sweep_idx_r == '1);

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the set-associative LRU translation buffer. Lookup,
// fill, flush and unused-kind words go in through a bursty sender while the result side
// stalls on its own pattern. A local copy of the entry array, stamps and
// totals predicts every result word, which is checked field by field in
// arrival order. Directed cases come first, then random phases at several
// page sizes, from zero to thirty-one.
// ----------------------------------------------------------------------------
module testbench;
  import salt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int ENTRIES = SETS * WAYS;
  localparam int CYCLE_LIMIT = 4_000_000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_word_t         in_word = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_word_t        out_word;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [LPS_W-1:0] cfg_data = '0;

  // predicted buffer contents
  bit               ent_valid [ENTRIES];
  bit [TAG_W-1:0]   ent_tag   [ENTRIES];
  bit [FRAME_W-1:0] ent_frame [ENTRIES];
  bit [STAMP_W-1:0] ent_stamp [ENTRIES];
  bit [STAMP_W-1:0] stamp_now;
  bit [CNT_W-1:0]   hit_count;
  bit [CNT_W-1:0]   miss_count;
  bit [CNT_W-1:0]   flush_count;
  bit [LPS_W-1:0]   page_shift = LPS_RESET;

  out_word_t        expected_results[$];
  out_word_t        exp_word;
  int unsigned      err_count;
  int unsigned      cycle_count;

  int unsigned      burst_left;
  bit               tx_steady;
  bit               rx_steady = 1'b1;
  int unsigned      ready_left;

  logic [TAG_W-1:0]    tag_pool[6];
  logic [LOG_SETS-1:0] set_pool[4];

  set_associative_lru_tlb i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (ready_left == 0) begin
      out_ready  <= rx_steady || !out_ready;
      ready_left <= out_ready ? $urandom_range(0, 6) : $urandom_range(0, 12);
    end else begin
      ready_left <= ready_left - 1;
    end
  end

  function automatic out_word_t tlb_outcome(in_word_t w);
    logic [VA_W-1:0]  vpn;
    logic [TAG_W-1:0] tag;
    int               base;
    int               way_hit;
    int               victim;
    out_word_t        r;
    vpn = w.virtual_address >> page_shift;
    base = int'(vpn[LOG_SETS-1:0]) * WAYS;
    tag = TAG_W'(vpn >> LOG_SETS);
    way_hit = -1;
    r = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (way_hit < 0 && ent_valid[base+i] && ent_tag[base+i] == tag) way_hit = i;
    end
    case (w.kind)
      KIND_LOOKUP: begin
        if (way_hit >= 0) begin
          r.hit = 1'b1;
          r.physical_frame = ent_frame[base+way_hit];
          hit_count++;
          stamp_now++;
          ent_stamp[base+way_hit] = stamp_now;
        end else begin
          miss_count++;
        end
      end
      KIND_FILL: begin
        if (w.translation != 0) begin
          victim = way_hit;
          for (int i = 0; i < WAYS; i++) begin
            if (victim < 0 && !ent_valid[base+i]) victim = i;
          end
          if (victim < 0) begin
            victim = 0;
            for (int i = 1; i < WAYS; i++) begin
              if (ent_stamp[base+i] < ent_stamp[base+victim]) victim = i;
            end
          end
          ent_valid[base+victim] = 1'b1;
          ent_tag[base+victim] = tag;
          ent_frame[base+victim] = w.translation;
          stamp_now++;
          ent_stamp[base+victim] = stamp_now;
        end
      end
      KIND_FLUSH: begin
        flush_count++;
        for (int i = 0; i < ENTRIES; i++) ent_valid[i] = 1'b0;
      end
      default: ;
    endcase
    r.hit_total = hit_count;
    r.miss_total = miss_count;
    r.flush_total = flush_count;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected: %p", out_word);
        err_count++;
      end else begin
        exp_word = expected_results.pop_front();
        if (out_word.hit !== exp_word.hit) begin
          $error("hit: expected %0d, got %0d", exp_word.hit, out_word.hit);
          err_count++;
        end
        if (out_word.physical_frame !== exp_word.physical_frame) begin
          $error("physical_frame: expected %h, got %h",
                 exp_word.physical_frame, out_word.physical_frame);
          err_count++;
        end
        if (out_word.hit_total !== exp_word.hit_total) begin
          $error("hit_total: expected %0d, got %0d", exp_word.hit_total, out_word.hit_total);
          err_count++;
        end
        if (out_word.miss_total !== exp_word.miss_total) begin
          $error("miss_total: expected %0d, got %0d",
                 exp_word.miss_total, out_word.miss_total);
          err_count++;
        end
        if (out_word.flush_total !== exp_word.flush_total) begin
          $error("flush_total: expected %0d, got %0d",
                 exp_word.flush_total, out_word.flush_total);
          err_count++;
        end
      end
    end
  end

  function automatic in_word_t make_word(logic [1:0] kind, logic [VA_W-1:0] va,
                                         logic [FRAME_W-1:0] tr);
    in_word_t w;
    w.kind = kind;
    w.virtual_address = va;
    w.translation = tr;
    return w;
  endfunction

  function automatic in_word_t random_word();
    in_word_t        w;
    int unsigned     pick;
    logic [VA_W-1:0] vpn;
    logic [VA_W-1:0] mask;
    pick = $urandom_range(0, 99);
    if (pick >= 94) begin
      w.kind = 2'($urandom_range(0, 3));
      w.virtual_address = $urandom;
      w.translation = $urandom;
      return w;
    end
    w.kind = (pick < 45) ? KIND_LOOKUP : (pick < 90) ? KIND_FILL :
             (pick < 92) ? KIND_FLUSH : KIND_UNUSED;
    vpn = {tag_pool[$urandom_range(0, 5)], set_pool[$urandom_range(0, 3)]};
    mask = (32'h1 << page_shift) - 1;
    if ($urandom_range(0, 4) == 0) w.virtual_address = $urandom;
    else w.virtual_address = (vpn << page_shift) | ($urandom & mask);
    w.translation = ($urandom_range(0, 9) == 0) ? '0 : $urandom;
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    int unsigned gap;
    in_word <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(tlb_outcome(w));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 7);
      gap = tx_steady ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_page_shift(logic [LPS_W-1:0] v);
    wait_drained();
    while (!in_ready) @(posedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    page_shift = v;
  endtask

  task automatic test_empty_lookup();
    send_word(make_word(KIND_LOOKUP, 32'h0000_0000, 32'h0));
    send_word(make_word(KIND_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
  endtask

  task automatic test_fill_hit();
    send_word(make_word(KIND_FILL, 32'h0000_0000, 32'hFFFF_FFFF));
    send_word(make_word(KIND_LOOKUP, 32'h0000_0FFF, 32'h0));
    send_word(make_word(KIND_FILL, 32'hFFFF_FFFF, 32'h0000_0001));
    send_word(make_word(KIND_LOOKUP, 32'hFFFF_F000, 32'h0));
    send_word(make_word(KIND_FILL, 32'h0000_0000, 32'h8000_0000));
    send_word(make_word(KIND_LOOKUP, 32'h0000_0000, 32'h0));
  endtask

  task automatic test_ignored_words();
    send_word(make_word(KIND_FILL, 32'h0000_1000, 32'h0));
    send_word(make_word(KIND_LOOKUP, 32'h0000_1000, 32'h0));
    send_word(make_word(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_word(make_word(KIND_LOOKUP, 32'h0000_0000, 32'h0));
  endtask

  // set 0: tag 0 in way 0, tag 1 fills way 1, tag 0 refreshed, tag 2 evicts tag 1
  task automatic test_lru_replacement();
    send_word(make_word(KIND_FILL, 32'h0040_0000, 32'h1234_5678));
    send_word(make_word(KIND_LOOKUP, 32'h0000_0000, 32'h0));
    send_word(make_word(KIND_FILL, 32'h0080_0000, 32'h9ABC_DEF0));
    send_word(make_word(KIND_LOOKUP, 32'h0040_0000, 32'h0));
    send_word(make_word(KIND_LOOKUP, 32'h0000_0000, 32'h0));
    send_word(make_word(KIND_LOOKUP, 32'h0080_0000, 32'h0));
  endtask

  task automatic test_flush();
    send_word(make_word(KIND_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_word(make_word(KIND_LOOKUP, 32'h0000_0000, 32'h0));
    send_word(make_word(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0));
    send_word(make_word(KIND_FILL, 32'h0000_0000, 32'h0BAD_F00D));
    send_word(make_word(KIND_LOOKUP, 32'h0000_0000, 32'h0));
  endtask

  task automatic test_page_size(logic [LPS_W-1:0] shift, int unsigned count);
    write_page_shift(shift);
    foreach (tag_pool[i]) tag_pool[i] = TAG_W'($urandom);
    foreach (set_pool[i]) set_pool[i] = LOG_SETS'($urandom);
    tx_steady = ($urandom_range(0, 3) == 0);
    rx_steady = ($urandom_range(0, 3) == 0);
    for (int unsigned i = 0; i < count; i++) begin
      if (i == count / 2) wait_drained();
      send_word(random_word());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    rx_steady = 1'b0;
    test_empty_lookup();
    test_fill_hit();
    test_ignored_words();
    test_lru_replacement();
    test_flush();
    test_page_size(LPS_RESET, 250);
    test_page_size(5'd0, 120);
    test_page_size(5'd31, 80);
    test_page_size(5'd2, 150);
    test_page_size(5'd20, 150);
    test_page_size(5'($urandom), 200);
    wait_drained();
    repeat (16) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ set_associative_lru_tlb.f @@
hw/rtl/salt_pkg.sv
hw/rtl/salt_ram.sv
hw/rtl/salt_ctrl.sv
hw/rtl/salt_dpath.sv
hw/rtl/set_associative_lru_tlb.sv
verif/testbench.sv
